>>> design/rlfg_pkg.sv
// shared types, constants and helpers for the rotating lagged fibonacci generator
package rlfg_pkg;

   localparam int DATA_W          = 32;
   localparam int FRAC_W          = 23;
   localparam int FRAC_LSB        = DATA_W - FRAC_W;
   localparam int RING_DEPTH_DEF  = 17;
   localparam int LAG_START_DEF   = 10;
   localparam int RSP_FIELDS_W    = DATA_W + FRAC_W + DATA_W;
   localparam int RSP_TDATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [DATA_W-1:0] LCG_MUL = 32'd2891336453;
   localparam logic [DATA_W-1:0] LCG_INC = 32'd1;
   localparam int ROT_LAG  = 13;
   localparam int ROT_DRAW = 9;

   // operation codes carried on req_tuser
   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // rotate left by a constant, nonzero amount
   function automatic logic [DATA_W-1:0] rotl(input logic [DATA_W-1:0] v, input int amount);
      rotl = (v << amount) | (v >> (DATA_W - amount));
   endfunction

endpackage

>>> design/rlfg_ring.sv
// word ring memory: one write port, two registered read ports
module rlfg_ring #(
   parameter int DEPTH = rlfg_pkg::RING_DEPTH_DEF,
   parameter int IDX_W = $clog2(rlfg_pkg::RING_DEPTH_DEF)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [rlfg_pkg::DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]            rd_addr_a,
   input  logic [IDX_W-1:0]            rd_addr_b,
   output logic [rlfg_pkg::DATA_W-1:0] rd_data_a,
   output logic [rlfg_pkg::DATA_W-1:0] rd_data_b
);

   logic [rlfg_pkg::DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

>>> design/rlfg_divider.sv
// iterative restoring divider, one dividend bit per cycle
module rlfg_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rlfg_pkg::DATA_W-1:0] dividend,
   input  logic [rlfg_pkg::DATA_W-1:0] divisor,
   output rlfg_pkg::div_status_type    status,
   output logic [rlfg_pkg::DATA_W-1:0] remainder
);

   localparam int W     = rlfg_pkg::DATA_W;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dvd_ff, dvd_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [W:0]       partial;
   logic [W:0]       diff;

   always_comb begin
      partial = {rem_ff, dvd_ff[W-1]};
      diff    = partial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // keep the partial remainder when the trial subtract goes negative
         rem_in = diff[W] ? partial[W-1:0] : diff[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

>>> design/rotating_lagged_fibonacci_rng.sv
// top level: sequencer, seed multiplier and result register of the lagged fibonacci generator
// draw: read, mix, the 32-step remainder divider, then the result register is loaded
//   (a zero bound skips the divider); ready again once the result is loaded
// reseed: one congruential multiply and one ring write per cycle, no result
// one item in flight at a time; req_tready is high only while the sequencer is idle
// synchronous active-high reset clears the sequencer, indices, item count and seed register;
//   the ring itself is not cleared and must be filled by a reseed before the first draw
module rotating_lagged_fibonacci_rng #(
   parameter int RING_DEPTH = rlfg_pkg::RING_DEPTH_DEF,
   parameter int LAG_START  = rlfg_pkg::LAG_START_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rlfg_pkg::DATA_W-1:0]      req_tdata,  // bound
   input  logic                             req_tuser,  // operation
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rlfg_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // random_word, unit_fraction,
                                                        // bounded_value, zero pad
   output logic                             rsp_tuser,  // bound_error
   // seed register
   input  logic                             csr_wr_en,
   input  logic [rlfg_pkg::DATA_W-1:0]      csr_wr_data
);

   localparam int W     = rlfg_pkg::DATA_W;
   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
   localparam logic [IDX_W-1:0] LAG_INIT = IDX_W'(LAG_START % RING_DEPTH);
   localparam int PAD_W = rlfg_pkg::RSP_TDATA_W - rlfg_pkg::RSP_FIELDS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEED,
      S_READ,
      S_MIX,
      S_DIV,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [W-1:0]     seed_ff, seed_in;         // seed register
   logic [W-1:0]     count_ff, count_in;       // accepted item count
   logic [IDX_W-1:0] draw_ff, draw_in;
   logic [IDX_W-1:0] lag_ff, lag_in;
   logic [IDX_W-1:0] fill_ff, fill_in;         // ring slot being seeded
   logic [W-1:0]     lcg_ff, lcg_in;           // congruential state
   logic [W-1:0]     bound_ff, bound_in;
   logic [W-1:0]     word_ff, word_in;
   logic [W-1:0]     mod_ff, mod_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]     rsp_word_ff, rsp_word_in;
   logic [W-1:0]     rsp_mod_ff, rsp_mod_in;
   logic             rsp_err_ff, rsp_err_in;

   logic [2*W-1:0]   lcg_prod;
   logic [W-1:0]     lcg_next;
   logic [W-1:0]     mixed;
   logic [W-1:0]     rd_draw, rd_lag;
   logic             ring_wr_en;
   logic [IDX_W-1:0] ring_wr_addr;
   logic [W-1:0]     ring_wr_data;
   logic             div_start;
   logic [W-1:0]     div_rem;
   logic             req_fire;
   rlfg_pkg::div_status_type div_status;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // one 32x32 multiplier steps the congruential sequence
   assign lcg_prod = lcg_ff * rlfg_pkg::LCG_MUL;
   assign lcg_next = lcg_prod[W-1:0] + rlfg_pkg::LCG_INC;

   // new ring word from the two registered read ports
   assign mixed = W'(rlfg_pkg::rotl(rd_lag, rlfg_pkg::ROT_LAG)
                   + rlfg_pkg::rotl(rd_draw, rlfg_pkg::ROT_DRAW));

   // ring write: seeding fill or draw update
   always_comb begin
      ring_wr_en   = 1'b0;
      ring_wr_addr = draw_ff;
      ring_wr_data = mixed;
      if (state_ff == S_SEED) begin
         ring_wr_en   = 1'b1;
         ring_wr_addr = fill_ff;
         ring_wr_data = lcg_next;
      end else if (state_ff == S_MIX) begin
         ring_wr_en = 1'b1;
      end
   end

   assign div_start = (state_ff == S_MIX) && (bound_ff != '0);

   rlfg_ring #(
      .DEPTH (RING_DEPTH),
      .IDX_W (IDX_W)
   ) u_ring (
      .clock     (clock),
      .wr_en     (ring_wr_en),
      .wr_addr   (ring_wr_addr),
      .wr_data   (ring_wr_data),
      .rd_addr_a (draw_ff),
      .rd_addr_b (lag_ff),
      .rd_data_a (rd_draw),
      .rd_data_b (rd_lag)
   );

   rlfg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mixed),
      .divisor   (bound_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      count_in     = count_ff;
      draw_in      = draw_ff;
      lag_in       = lag_ff;
      fill_in      = fill_ff;
      lcg_in       = lcg_ff;
      bound_in     = bound_ff;
      word_in      = word_ff;
      mod_in       = mod_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_mod_in   = rsp_mod_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               count_in = count_ff + 1'b1;
               bound_in = req_tdata;
               if (req_tuser == rlfg_pkg::OP_RESEED) begin
                  // zero seed falls back to the item count before this item
                  lcg_in   = (seed_ff == '0) ? count_ff : seed_ff;
                  fill_in  = '0;
                  state_in = S_SEED;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_SEED: begin
            lcg_in  = lcg_next;
            fill_in = fill_ff + 1'b1;
            if (fill_ff == IDX_LAST) begin
               draw_in  = '0;
               lag_in   = LAG_INIT;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            // ring read data lands at the end of this cycle
            state_in = S_MIX;
         end
         S_MIX: begin
            word_in = mixed;
            draw_in = (draw_ff == '0) ? IDX_LAST : draw_ff - 1'b1;
            lag_in  = (lag_ff == '0) ? IDX_LAST : lag_ff - 1'b1;
            if (bound_ff == '0) begin
               mod_in   = '0;
               err_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               err_in   = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               mod_in   = div_rem;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = word_ff;
               rsp_mod_in   = mod_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= '0;
         count_ff     <= '0;
         draw_ff      <= '0;
         lag_ff       <= LAG_INIT;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         count_ff     <= count_in;
         draw_ff      <= draw_in;
         lag_ff       <= lag_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lcg_ff      <= lcg_in;
      bound_ff    <= bound_in;
      word_ff     <= word_in;
      mod_ff      <= mod_in;
      err_ff      <= err_in;
      rsp_word_ff <= rsp_word_in;
      rsp_mod_ff  <= rsp_mod_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // result packing: word, fraction (top bits of the word), bounded value
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_mod_ff,
                        rsp_word_ff[W-1:rlfg_pkg::FRAC_LSB], rsp_word_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

>>> sim/rotating_lagged_fibonacci_rng_tb.sv
// self-checking testbench for the rotating lagged fibonacci generator
module rotating_lagged_fibonacci_rng_tb;

   localparam int RING = rlfg_pkg::RING_DEPTH_DEF;
   localparam int LAG  = rlfg_pkg::LAG_START_DEF;
   localparam int DW   = rlfg_pkg::DATA_W;
   localparam int FW   = rlfg_pkg::FRAC_W;
   // a reseed gives no result, so wait it out before a csr write
   localparam int SETTLE_CYCLES = RING + 24;
   localparam int RANDOM_ITEMS  = 1820;
   localparam int SEED_PHASES   = 8;

   // one expected draw result, with the fields carried on rsp_tdata and rsp_tuser
   typedef struct packed {
      logic [DW-1:0] word;
      logic [FW-1:0] fraction;
      logic [DW-1:0] residue;
      logic          zero_bound;
   } draw_outcome_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [DW-1:0]                    req_tdata   = '0;
   logic                             req_tuser   = rlfg_pkg::OP_DRAW;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [rlfg_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_wr_en   = 1'b0;
   logic [DW-1:0]                    csr_wr_data = '0;

   // shadow copy of the generator state
   logic [DW-1:0]     ring_copy [RING];
   int unsigned       draw_pos;
   int unsigned       lag_pos;
   logic [DW-1:0]     items_seen;
   logic [DW-1:0]     seed_copy;
   draw_outcome_type  pending_draws [$];

   int   fault_count = 0;
   bit   gaps_on     = 1'b1;   // cleared for stretches with no idling on either side
   bit   req_held    = 1'b0;   // req_tvalid currently driven high
   int unsigned rsp_hold = 0;

   always #4 clock = ~clock;

   rotating_lagged_fibonacci_rng #(
      .RING_DEPTH (RING),
      .LAG_START  (LAG)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // rotate left through a doubled word
   function automatic logic [DW-1:0] rotl_word(input logic [DW-1:0] v,
                                               input int amount);
      logic [2*DW-1:0] twice;
      twice = {v, v} << amount;
      return twice[2*DW-1:DW];
   endfunction

   // indices step down and wrap from 0 to the top of the ring
   function automatic int unsigned ring_prev(input int unsigned idx);
      return (idx == 0) ? RING - 1 : idx - 1;
   endfunction

   // advance the shadow generator by one accepted item, queue the draw result
   function automatic void advance_generator(input logic op, input logic [DW-1:0] bound);
      logic [DW-1:0]    s;
      logic [DW-1:0]    word;
      draw_outcome_type res;
      if (op == rlfg_pkg::OP_RESEED) begin
         // zero seed register selects the item count taken before this item
         s = (seed_copy == '0) ? items_seen : seed_copy;
         for (int i = 0; i < RING; i++) begin
            s = s * rlfg_pkg::LCG_MUL + rlfg_pkg::LCG_INC;
            ring_copy[i] = s;
         end
         draw_pos = 0;
         lag_pos  = LAG % RING;
      end else begin
         word = rotl_word(ring_copy[lag_pos], rlfg_pkg::ROT_LAG)
              + rotl_word(ring_copy[draw_pos], rlfg_pkg::ROT_DRAW);
         ring_copy[draw_pos] = word;
         draw_pos = ring_prev(draw_pos);
         lag_pos  = ring_prev(lag_pos);
         res.word       = word;
         res.fraction   = word[DW-1:rlfg_pkg::FRAC_LSB];
         res.zero_bound = (bound == '0);
         res.residue    = (bound == '0) ? '0 : word % bound;
         pending_draws.push_back(res);
      end
      items_seen = items_seen + 1;
   endfunction

   // mix of zero, small, power-of-two, near-maximum and full-range bounds
   function automatic logic [DW-1:0] random_bound();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return $urandom_range(1, 16);
         end
         2: begin
            return 32'd1 << $urandom_range(0, 31);
         end
         3: begin
            return ~$urandom_range(0, 15);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // present one item and wait for it to be taken; valid stays up for a back-to-back item
   task automatic send_item(input logic op, input logic [DW-1:0] bound);
      int gap;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         if (req_held) begin
            req_tvalid <= 1'b0;
            req_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= bound;
      req_held = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_generator(op, bound);
   endtask

   // drop valid, drain all results and let a trailing reseed finish
   task automatic wait_idle();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
         @(posedge clock);
      end
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [DW-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      seed_copy = value;
   endtask

   // seed register still at reset: first reseed takes the item count, which is zero
   task automatic test_first_reseed_from_count();
      send_item(rlfg_pkg::OP_RESEED, $urandom);
      send_item(rlfg_pkg::OP_DRAW, '0);
      send_item(rlfg_pkg::OP_DRAW, 32'd1);
      send_item(rlfg_pkg::OP_DRAW, 32'hFFFF_FFFF);
   endtask

   task automatic test_bound_extremes();
      send_item(rlfg_pkg::OP_DRAW, 32'h8000_0000);
      send_item(rlfg_pkg::OP_DRAW, 32'd2);
      send_item(rlfg_pkg::OP_DRAW, 32'hFFFF_FFFE);
      send_item(rlfg_pkg::OP_DRAW, 32'd3);
      send_item(rlfg_pkg::OP_DRAW, '0);
   endtask

   // enough draws for both indices to wrap past zero
   task automatic test_index_wrap();
      for (int n = 0; n < 10; n++) send_item(rlfg_pkg::OP_DRAW, random_bound());
   endtask

   // all-ones and one as seeds, then zero again so the nonzero item count is used
   task automatic test_seed_register_extremes();
      write_seed(32'hFFFF_FFFF);
      send_item(rlfg_pkg::OP_RESEED, '0);
      send_item(rlfg_pkg::OP_DRAW, $urandom);
      write_seed(32'd1);
      send_item(rlfg_pkg::OP_RESEED, 32'hFFFF_FFFF);
      send_item(rlfg_pkg::OP_DRAW, $urandom);
      write_seed('0);
      send_item(rlfg_pkg::OP_RESEED, $urandom);
      send_item(rlfg_pkg::OP_DRAW, $urandom);
   endtask

   // phases of mostly draws with a few reseeds, each under a new seed setting
   task automatic test_random_traffic(input int total);
      int            per_phase;
      logic [DW-1:0] seed;
      per_phase = total / SEED_PHASES;
      for (int p = 0; p < SEED_PHASES; p++) begin
         case (p % 4)
            0: begin
               seed = '0;
            end
            1: begin
               seed = 32'hFFFF_FFFF;
            end
            2: begin
               seed = $urandom;
            end
            default: begin
               seed = 32'd1 << $urandom_range(0, 31);
            end
         endcase
         write_seed(seed);
         send_item(rlfg_pkg::OP_RESEED, $urandom);
         for (int n = 1; n < per_phase; n++) begin
            if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 6) begin
               send_item(rlfg_pkg::OP_RESEED, $urandom);
            end else begin
               send_item(rlfg_pkg::OP_DRAW, random_bound());
            end
         end
         gaps_on = 1'b1;
      end
   endtask

   // result side: random stall while a result waits, compare against the oldest draw
   always @(posedge clock) begin : check_results
      draw_outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            $error("result item with no draw outstanding");
            fault_count++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_tdata[DW-1:0] !== want.word) begin
               $error("random_word expected %h actual %h", want.word, rsp_tdata[DW-1:0]);
               fault_count++;
            end
            if (rsp_tdata[DW+FW-1:DW] !== want.fraction) begin
               $error("unit_fraction expected %h actual %h", want.fraction,
                      rsp_tdata[DW+FW-1:DW]);
               fault_count++;
            end
            if (rsp_tdata[2*DW+FW-1:DW+FW] !== want.residue) begin
               $error("bounded_value expected %h actual %h", want.residue,
                      rsp_tdata[2*DW+FW-1:DW+FW]);
               fault_count++;
            end
            if (rsp_tuser !== want.zero_bound) begin
               $error("bound_error expected %b actual %b", want.zero_bound, rsp_tuser);
               fault_count++;
            end
         end
         rsp_hold = gaps_on ? $urandom_range(0, 8) : 0;
         rsp_tready <= (rsp_hold == 0);
      end else if (rsp_tvalid) begin
         if (rsp_hold > 0) rsp_hold--;
         if (rsp_hold == 0) rsp_tready <= 1'b1;
      end else if (rsp_hold == 0) begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      for (int i = 0; i < RING; i++) ring_copy[i] = '0;
      draw_pos   = 0;
      lag_pos    = LAG % RING;
      items_seen = '0;
      seed_copy  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_reseed_from_count();
      test_bound_extremes();
      test_index_wrap();
      test_seed_register_extremes();
      test_random_traffic(RANDOM_ITEMS);
      wait_idle();
      if (fault_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #8000000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
design/rlfg_pkg.sv
design/rlfg_ring.sv
design/rlfg_divider.sv
design/rotating_lagged_fibonacci_rng.sv
sim/rotating_lagged_fibonacci_rng_tb.sv
